// File: sv/hrht_pkg.sv
// shared types and constants of the http request header tokenizer
package hrht_pkg;

  localparam int MAX_HEADER_BYTES = 8192;
  localparam int MAX_FIELDS = 255;

  localparam int POS_W = 13;
  localparam int OFF_W = 14;
  localparam int KIND_W = 4;
  localparam int LIM_W = 14;
  localparam int FLD_W = 8;

  // hard caps on the programmable limits
  localparam int BYTE_CAP = (MAX_HEADER_BYTES < 8192) ? MAX_HEADER_BYTES : 8192;
  localparam int FIELD_CAP = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;

  localparam logic [LIM_W-1:0] BYTE_LIMIT_RESET = LIM_W'(8192);
  localparam logic [FLD_W-1:0] FIELD_LIMIT_RESET = FLD_W'(30);

  // token kinds
  localparam logic [KIND_W-1:0] KIND_METHOD     = 4'd0;
  localparam logic [KIND_W-1:0] KIND_URI        = 4'd1;
  localparam logic [KIND_W-1:0] KIND_VERSION    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_KEY        = 4'd3;
  localparam logic [KIND_W-1:0] KIND_VALUE      = 4'd4;
  localparam logic [KIND_W-1:0] KIND_HEADER_END = 4'd5;
  localparam logic [KIND_W-1:0] KIND_BAD_LINE   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_ORPHAN     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_INCOMPLETE = 4'd8;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW   = 4'd9;

  // register indexes
  localparam logic REG_BYTE_LIMIT = 1'b0;
  localparam logic REG_FIELD_LIMIT = 1'b1;

  // characters
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_SP = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;

  typedef struct packed {
    logic [LIM_W-1:0] byte_limit;
    logic [FLD_W-1:0] field_limit;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] length;
    logic last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t first;
    token_t second;
  } push_t;

endpackage

// File: sv/hrht_in_if.sv
// byte channel into the tokenizer
interface hrht_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic starts_message;
  logic ends_data;

  modport source(output valid, output data_byte, output starts_message, output ends_data,
                 input ready);
  modport sink(input valid, input data_byte, input starts_message, input ends_data,
               output ready);
endinterface

// File: sv/hrht_out_if.sv
// token channel out of the tokenizer
interface hrht_out_if
  import hrht_pkg::*;
();
  logic valid;
  logic ready;
  logic [KIND_W-1:0] token_kind;
  logic [POS_W-1:0] token_start;
  logic [POS_W-1:0] token_length;
  logic last_of_run;

  modport source(output valid, output token_kind, output token_start, output token_length,
                 output last_of_run, input ready);
  modport sink(input valid, input token_kind, input token_start, input token_length,
               input last_of_run, output ready);
endinterface

// File: sv/hrht_parser.sv
// per-byte parse state and token generation
module hrht_parser
  import hrht_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       room,
  hrht_in_if.sink    bytes,
  output push_t      push
);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_RL_SKIP    = 4'd1;
  localparam logic [3:0] PH_METHOD     = 4'd2;
  localparam logic [3:0] PH_URI        = 4'd3;
  localparam logic [3:0] PH_VERSION    = 4'd4;
  localparam logic [3:0] PH_LINE_SKIP  = 4'd5;
  localparam logic [3:0] PH_KEY        = 4'd6;
  localparam logic [3:0] PH_VALUE_LEAD = 4'd7;
  localparam logic [3:0] PH_VALUE      = 4'd8;

  localparam logic [2:0] TERM_BROKEN = 3'd7;
  localparam logic [2:0] TERM_DONE = 3'd4;

  logic [3:0] phase, phase_next;
  logic [OFF_W-1:0] off, off_next;
  logic [POS_W-1:0] tbeg, tbeg_next;
  logic [FLD_W-1:0] fields, fields_next;
  logic [2:0] term, term_next;

  logic accept;
  logic [7:0] b;
  logic eol, blank;
  logic [3:0] ph;
  logic [OFF_W-1:0] o;
  logic [POS_W-1:0] tb, o13, tok_len, key_begin;
  logic [FLD_W-1:0] fs;
  logic [2:0] tp;
  logic [OFF_W-1:0] byte_lim;
  logic [FLD_W-1:0] fld_lim;
  logic key_active;
  logic e0_valid, e1_valid;
  token_t e0, e1;

  assign bytes.ready = room;
  assign accept = bytes.valid && room;
  assign b = bytes.data_byte;
  assign eol = (b == CH_CR) || (b == CH_LF);
  assign blank = eol || (b == CH_SP);

  assign byte_lim = (cfg.byte_limit > LIM_W'(BYTE_CAP)) ? LIM_W'(BYTE_CAP) : cfg.byte_limit;
  assign fld_lim = (cfg.field_limit > FLD_W'(FIELD_CAP)) ? FLD_W'(FIELD_CAP) : cfg.field_limit;

  always_comb begin
    // a message start resets the state before the byte is handled
    ph = bytes.starts_message ? PH_RL_SKIP : phase;
    o = bytes.starts_message ? '0 : off;
    tb = bytes.starts_message ? '0 : tbeg;
    fs = bytes.starts_message ? '0 : fields;
    tp = bytes.starts_message ? '0 : term;
    o13 = o[POS_W-1:0];
    tok_len = o13 - tb;
    key_begin = (ph == PH_KEY) ? tb : o13;
    key_active = 1'b0;

    phase_next = phase;
    off_next = off;
    tbeg_next = tbeg;
    fields_next = fields;
    term_next = term;
    e0_valid = 1'b0;
    e1_valid = 1'b0;
    e0 = '0;
    e1 = '0;

    if (accept && ph != PH_IDLE) begin
      phase_next = ph;
      off_next = o;
      tbeg_next = tb;
      fields_next = fs;
      term_next = tp;
      if (o >= byte_lim) begin
        e0_valid = 1'b1;
        e0.kind = KIND_OVERFLOW;
        e0.start = (o > OFF_W'(8191)) ? POS_W'(8191) : o13;
        phase_next = PH_IDLE;
      end else begin
        off_next = o + OFF_W'(1);
        unique case (ph)
          PH_RL_SKIP: begin
            if (!blank) begin
              phase_next = PH_METHOD;
              tbeg_next = o13;
            end
          end
          PH_METHOD, PH_URI: begin
            if (b == CH_SP) begin
              e0_valid = 1'b1;
              e0.kind = (ph == PH_METHOD) ? KIND_METHOD : KIND_URI;
              e0.start = tb;
              e0.length = tok_len;
              tbeg_next = o13 + POS_W'(1);
              phase_next = (ph == PH_METHOD) ? PH_URI : PH_VERSION;
            end else if (eol) begin
              e0_valid = 1'b1;
              e0.kind = KIND_BAD_LINE;
              e0.start = o13;
              phase_next = PH_IDLE;
            end
          end
          PH_VERSION: begin
            if (eol) begin
              e0_valid = 1'b1;
              e0.kind = KIND_VERSION;
              e0.start = tb;
              e0.length = tok_len;
              phase_next = PH_LINE_SKIP;
              term_next = (b == CH_CR) ? 3'd1 : TERM_BROKEN;
            end
          end
          PH_LINE_SKIP: begin
            if (blank) begin
              // cr lf cr lf: even steps expect cr, odd steps lf
              if (tp < TERM_DONE && b == (tp[0] ? CH_LF : CH_CR)) begin
                term_next = tp + 3'd1;
                if (tp == 3'd3) begin
                  e0_valid = 1'b1;
                  e0.kind = KIND_HEADER_END;
                  e0.start = o13;
                  phase_next = PH_IDLE;
                end
              end else begin
                term_next = TERM_BROKEN;
              end
            end else begin
              key_active = 1'b1;
            end
          end
          PH_KEY: key_active = 1'b1;
          PH_VALUE_LEAD, PH_VALUE: begin
            if (eol) begin
              e0_valid = 1'b1;
              e0.kind = KIND_VALUE;
              e0.start = tb;
              e0.length = tok_len;
              phase_next = PH_LINE_SKIP;
              term_next = (b == CH_CR) ? 3'd1 : TERM_BROKEN;
            end else if (ph == PH_VALUE_LEAD) begin
              if (b == CH_SP) begin
                tbeg_next = o13 + POS_W'(1);
              end else begin
                phase_next = PH_VALUE;
              end
            end
          end
          default: phase_next = PH_IDLE;
        endcase

        // first byte of a field line is handled as key data too
        if (key_active) begin
          phase_next = PH_KEY;
          tbeg_next = key_begin;
          if (b == CH_COLON) begin
            if (fs >= fld_lim) begin
              e0_valid = 1'b1;
              e0.kind = KIND_OVERFLOW;
              e0.start = o13;
              phase_next = PH_IDLE;
            end else begin
              e0_valid = 1'b1;
              e0.kind = KIND_KEY;
              e0.start = key_begin;
              e0.length = o13 - key_begin;
              fields_next = fs + FLD_W'(1);
              tbeg_next = o13 + POS_W'(1);
              phase_next = PH_VALUE_LEAD;
            end
          end else if (eol) begin
            if (fs == '0) begin
              e0_valid = 1'b1;
              e0.kind = KIND_ORPHAN;
              e0.start = o13;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_LINE_SKIP;
              term_next = (b == CH_CR) ? 3'd1 : TERM_BROKEN;
            end
          end
        end

        if (bytes.ends_data) begin
          if (phase_next != PH_IDLE) begin
            e1_valid = 1'b1;
            e1.kind = KIND_INCOMPLETE;
            e1.start = o13;
          end
          phase_next = PH_IDLE;
        end
      end
    end
  end

  always_comb begin
    push = '0;
    if (e0_valid) begin
      push.first = e0;
      push.first.last = !e1_valid;
      push.second = e1;
      push.second.last = 1'b1;
      push.count = e1_valid ? 2'd2 : 2'd1;
    end else if (e1_valid) begin
      push.first = e1;
      push.first.last = 1'b1;
      push.count = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      off <= '0;
      tbeg <= '0;
      fields <= '0;
      term <= '0;
    end else begin
      phase <= phase_next;
      off <= off_next;
      tbeg <= tbeg_next;
      fields <= fields_next;
      term <= term_next;
    end
  end

endmodule

// File: sv/hrht_fifo.sv
// small result queue that takes up to two tokens a cycle and hands out one
module hrht_fifo
  import hrht_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       room,
  hrht_out_if.source tokens
);

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  token_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;
  logic pop;
  token_t head;

  assign head = slots[rd_ptr];
  assign tokens.valid = (count != '0);
  assign tokens.token_kind = head.kind;
  assign tokens.token_start = head.start;
  assign tokens.token_length = head.length;
  assign tokens.last_of_run = head.last;
  assign pop = tokens.valid && tokens.ready;
  // room for a full two-token run
  assign room = (count <= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      rd_ptr <= rd_ptr + AW'(pop);
      count <= count + (AW+1)'(push.count) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + AW'(1)] <= push.second;
    end
  end

endmodule

// File: sv/http_request_header_tokenizer.sv
// top level of the http request header tokenizer
// a byte's tokens are written into the result queue and reach the output from its head
// throughput: one byte per cycle while the result queue has room; a byte with two tokens takes two output words
// input ready drops only while more than two tokens wait in the result queue
// reset (rst, synchronous, active high) empties the queue, idles the parser and
// restores the limits to 8192 bytes and 30 fields
module http_request_header_tokenizer
  import hrht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hrht_in_if.sink     bytes,
  hrht_out_if.source  tokens,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  push_t push;
  logic room;
  logic cfg_write;

  // apb: no wait states; registers at byte offsets 0 and 4
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.byte_limit <= BYTE_LIMIT_RESET;
      cfg.field_limit <= FIELD_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_BYTE_LIMIT:  cfg.byte_limit <= pwdata[LIM_W-1:0];
        REG_FIELD_LIMIT: cfg.field_limit <= pwdata[FLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BYTE_LIMIT:  prdata = {{(32-LIM_W){1'b0}}, cfg.byte_limit};
      REG_FIELD_LIMIT: prdata = {{(32-FLD_W){1'b0}}, cfg.field_limit};
      default:         prdata = '0;
    endcase
  end

  // parse state and per-byte token decisions; bytes are taken only when
  // the queue can absorb a full run of two tokens
  hrht_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .room  (room),
    .bytes (bytes),
    .push  (push)
  );

  // result queue decouples the token sink from the byte source
  hrht_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

endmodule

// File: sv/hrht_checker.sv
// port-level checks of the tokenizer and their bind
module hrht_checker
  import hrht_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              tok_valid,
  input logic              tok_ready,
  input logic [KIND_W-1:0] tok_kind,
  input logic [POS_W-1:0]  tok_start,
  input logic [POS_W-1:0]  tok_length,
  input logic              tok_last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid)
    else $error("token word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> $stable({tok_kind, tok_start, tok_length, tok_last}))
    else $error("token word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !tok_valid)
    else $error("token word present right after reset");

  a_marker_len: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_kind >= KIND_HEADER_END |-> tok_length == '0)
    else $error("end or error token with nonzero length");

  a_run_pair: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready && !tok_last |=> tok_valid)
    else $error("second token of a run missing");

endmodule

bind http_request_header_tokenizer hrht_checker u_check (
  .clk        (clk),
  .rst        (rst),
  .tok_valid  (tokens.valid),
  .tok_ready  (tokens.ready),
  .tok_kind   (tokens.token_kind),
  .tok_start  (tokens.token_start),
  .tok_length (tokens.token_length),
  .tok_last   (tokens.last_of_run)
);
